FILE: rtl/three_operand_cpu_execute_top_defines.svh
// ============================================================================
// Assertion macros for the three-operand execute block
// Shared helpers that wrap concurrent assertions on i_clk and i_rst_n.
// ============================================================================
`ifndef THREE_OPERAND_CPU_EXECUTE_TOP_DEFINES_SVH
`define THREE_OPERAND_CPU_EXECUTE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TOCE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TOCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/toce_pkg.sv
// ============================================================================
// toce_pkg
// Types, opcodes and sizes shared by the three-operand execute block.
// ============================================================================
`default_nettype none

package toce_pkg;

    localparam int XLEN      = 32;
    localparam int PC_W      = 12;
    localparam int NUM_REGS  = 16;
    localparam int REG_AW    = $clog2(NUM_REGS);
    // The data memory depth must be a power of two.
    localparam int MEM_DEPTH = 4096;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int IO_REGS   = 32;
    localparam int IO_AW     = 5;

    localparam logic [4:0] OP_ADD  = 5'd0;
    localparam logic [4:0] OP_SUB  = 5'd1;
    localparam logic [4:0] OP_MAC  = 5'd2;
    localparam logic [4:0] OP_AND  = 5'd3;
    localparam logic [4:0] OP_OR   = 5'd4;
    localparam logic [4:0] OP_XOR  = 5'd5;
    localparam logic [4:0] OP_SLL  = 5'd6;
    localparam logic [4:0] OP_SRA  = 5'd7;
    localparam logic [4:0] OP_SRL  = 5'd8;
    localparam logic [4:0] OP_BEQ  = 5'd9;
    localparam logic [4:0] OP_BNE  = 5'd10;
    localparam logic [4:0] OP_BLT  = 5'd11;
    localparam logic [4:0] OP_BGT  = 5'd12;
    localparam logic [4:0] OP_BLE  = 5'd13;
    localparam logic [4:0] OP_BGE  = 5'd14;
    localparam logic [4:0] OP_JAL  = 5'd15;
    localparam logic [4:0] OP_LW   = 5'd16;
    localparam logic [4:0] OP_SW   = 5'd17;
    localparam logic [4:0] OP_RETI = 5'd18;
    localparam logic [4:0] OP_IN   = 5'd19;
    localparam logic [4:0] OP_OUT  = 5'd20;
    localparam logic [4:0] OP_HALT = 5'd21;

    localparam logic [1:0] IO_NONE  = 2'd0;
    localparam logic [1:0] IO_READ  = 2'd1;
    localparam logic [1:0] IO_WRITE = 2'd2;

    localparam logic [IO_AW-1:0] IO_RET_INDEX    = 5'd7;
    localparam logic [IO_AW-1:0] IO_MONCMD_INDEX = 5'd22;

    localparam logic [REG_AW-1:0] REG_ZERO       = 4'd0;
    localparam logic [REG_AW-1:0] REG_IMM_FIRST  = 4'd1;
    localparam logic [REG_AW-1:0] REG_IMM_SECOND = 4'd2;
    localparam logic [REG_AW-1:0] FIRST_WRITABLE = 4'd3;

    typedef struct packed {
        logic [4:0]         op;
        logic [3:0]         dest_reg;
        logic [3:0]         src_a_reg;
        logic [3:0]         src_b_reg;
        logic [3:0]         src_c_reg;
        logic signed [11:0] imm_first;
        logic signed [11:0] imm_second;
    } t_in;

    typedef struct packed {
        logic [11:0]        next_pc;
        logic               halted;
        logic               interrupt_returned;
        logic               reg_written;
        logic signed [31:0] write_value;
        logic [1:0]         io_access;
        logic [4:0]         io_index;
        logic signed [31:0] io_data;
        logic               mem_written;
        logic [11:0]        mem_address;
        logic signed [31:0] mem_data;
    } t_out;

    typedef struct packed {
        logic              re;
        logic [REG_AW-1:0] addr_a;
        logic [REG_AW-1:0] addr_b;
        logic [REG_AW-1:0] addr_c;
        logic [REG_AW-1:0] addr_d;
    } t_rf_rd;

    typedef struct packed {
        logic              we;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } t_rf_wr;

    typedef struct packed {
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] b;
        logic [XLEN-1:0] c;
        logic [XLEN-1:0] d;
    } t_rf_q;

    typedef struct packed {
        logic              re;
        logic              we;
        logic [MEM_AW-1:0] addr;
        logic [XLEN-1:0]   wdata;
    } t_dm_req;

endpackage

`default_nettype wire

FILE: rtl/toce_regfile.sv
// ============================================================================
// toce_regfile
// Register file with four read ports built from two dual-read banks,
// per-entry valid bits for the reset value and same-edge write bypass.
// ============================================================================
`default_nettype none
`include "three_operand_cpu_execute_top_defines.svh"

module toce_regfile (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  toce_pkg::t_rf_rd  i_rd,
    input  toce_pkg::t_rf_wr  i_wr,
    output toce_pkg::t_rf_q   o_q
);

    logic [toce_pkg::XLEN-1:0]     r_bank_ab [toce_pkg::NUM_REGS];
    logic [toce_pkg::XLEN-1:0]     r_bank_cd [toce_pkg::NUM_REGS];
    logic [toce_pkg::NUM_REGS-1:0] r_vld;
    logic [toce_pkg::XLEN-1:0]     r_qa;
    logic [toce_pkg::XLEN-1:0]     r_qb;
    logic [toce_pkg::XLEN-1:0]     r_qc;
    logic [toce_pkg::XLEN-1:0]     r_qd;
    logic [toce_pkg::XLEN-1:0]     r_byp;
    logic [3:0]                    r_qv;
    logic [3:0]                    r_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_bank_ab[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.re) begin
            r_qa <= r_bank_ab[i_rd.addr_a];
            r_qb <= r_bank_ab[i_rd.addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_bank_cd[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.re) begin
            r_qc <= r_bank_cd[i_rd.addr_c];
            r_qd <= r_bank_cd[i_rd.addr_d];
        end
    end

    // A write on the same edge as a read is taken from the bypass register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_qv  <= '0;
            r_hit <= '0;
        end else begin
            if (i_wr.we) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd.re) begin
                r_qv  <= {r_vld[i_rd.addr_d], r_vld[i_rd.addr_c],
                          r_vld[i_rd.addr_b], r_vld[i_rd.addr_a]};
                r_hit <= {i_wr.we && (i_wr.addr == i_rd.addr_d),
                          i_wr.we && (i_wr.addr == i_rd.addr_c),
                          i_wr.we && (i_wr.addr == i_rd.addr_b),
                          i_wr.we && (i_wr.addr == i_rd.addr_a)};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.re) begin
            r_byp <= i_wr.data;
        end
    end

    assign o_q.a = r_hit[0] ? r_byp : (r_qv[0] ? r_qa : '0);
    assign o_q.b = r_hit[1] ? r_byp : (r_qv[1] ? r_qb : '0);
    assign o_q.c = r_hit[2] ? r_byp : (r_qv[2] ? r_qc : '0);
    assign o_q.d = r_hit[3] ? r_byp : (r_qv[3] ? r_qd : '0);

    `TOCE_ASSERT_SAME(a_no_fixed_write, i_wr.we, i_wr.addr >= toce_pkg::FIRST_WRITABLE, "write to a fixed register")
    `TOCE_ASSERT_NEXT(a_write_sets_valid, i_wr.we, r_vld[$past(i_wr.addr)], "valid bit not set by write")
    `TOCE_ASSERT_NEXT(a_bypass_a, i_rd.re && i_wr.we && (i_wr.addr == i_rd.addr_a), o_q.a == $past(i_wr.data), "bypass missed on port a")

endmodule

`default_nettype wire

FILE: rtl/toce_dmem.sv
// ============================================================================
// toce_dmem
// Word-addressed data memory with one registered read port, one write port
// and a clearing sweep after reset.
// ============================================================================
`default_nettype none

module toce_dmem (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  toce_pkg::t_dm_req         i_req,
    output logic [toce_pkg::XLEN-1:0] o_rdata,
    output logic                      o_busy
);

    logic [toce_pkg::XLEN-1:0]   r_mem [toce_pkg::MEM_DEPTH];
    logic [toce_pkg::XLEN-1:0]   r_rdata;
    logic                        r_busy;
    logic [toce_pkg::MEM_AW-1:0] r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (&r_clr_idx) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

`default_nettype wire

FILE: rtl/three_operand_cpu_execute_top.sv
// ============================================================================
// three_operand_cpu_execute_top
// Execute stage of a small three-operand processor: register file and data
// memory reads, operation, writeback and one result per instruction.
// ============================================================================
//
// Channel  Dir  Handshake                  Payload
// in       in   i_in_valid / o_in_stall    i_in_item  (toce_pkg::t_in)
// out      out  o_out_valid / i_out_stall  o_out_item (toce_pkg::t_out)
//
// A new instruction is taken every cycle while the output is not stalled
// and no load or multiply-accumulate is in flight. Operands come from the
// register file in the cycle after the transfer. Load and MAC also pass
// the data memory read port or the product register before writeback.
// After reset the data memory is cleared with no input transfer. An output
// stall holds the result and, once the operand stage is full, stops input.
// ============================================================================
`default_nettype none
`include "three_operand_cpu_execute_top_defines.svh"

module three_operand_cpu_execute_top #(
    parameter int IO_REGS = toce_pkg::IO_REGS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  toce_pkg::t_in   i_in_item,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output toce_pkg::t_out  o_out_item
);

    localparam int IoDepth = (IO_REGS < 32) ? IO_REGS : 32;
    localparam logic [toce_pkg::IO_AW:0] IoLimit = 6'(IoDepth);

    logic                          r_d_vld;
    toce_pkg::t_in                 r_d;
    logic                          r_l_vld;
    logic                          r_l_lw;
    logic [3:0]                    r_l_rd;
    logic [toce_pkg::XLEN-1:0]     r_l_c;
    logic [toce_pkg::XLEN-1:0]     r_l_prod;
    toce_pkg::t_out                r_l_out;
    logic                          r_o_vld;
    toce_pkg::t_out                r_o;
    logic [toce_pkg::PC_W-1:0]     r_pc;
    logic                          r_halt;
    logic [toce_pkg::XLEN-1:0]     r_io [IoDepth];

    toce_pkg::t_rf_rd              rf_rd;
    toce_pkg::t_rf_wr              rf_wr;
    toce_pkg::t_rf_q               rf_q;
    toce_pkg::t_dm_req             dm_req;
    logic [toce_pkg::XLEN-1:0]     dm_rdata;
    logic                          dm_busy;

    logic                          out_free;
    logic                          d_go;
    logic                          l_go;
    logic                          in_ready;
    logic                          accept;

    logic [toce_pkg::XLEN-1:0]     imm1;
    logic [toce_pkg::XLEN-1:0]     imm2;
    logic [toce_pkg::XLEN-1:0]     op_a;
    logic [toce_pkg::XLEN-1:0]     op_b;
    logic [toce_pkg::XLEN-1:0]     op_c;
    logic [toce_pkg::XLEN-1:0]     op_d;
    logic [toce_pkg::XLEN-1:0]     sum_ab;
    logic [toce_pkg::XLEN-1:0]     mem_full;
    logic [4:0]                    sh;
    logic [toce_pkg::IO_AW-1:0]    io_idx;
    logic                          io_ok;
    logic [toce_pkg::XLEN-1:0]     io_rd;
    logic [toce_pkg::XLEN-1:0]     sw_data;
    logic [toce_pkg::PC_W-1:0]     pc_inc;
    logic [toce_pkg::PC_W-1:0]     target;
    logic                          lt_ab;
    logic                          lt_ba;

    toce_pkg::t_out                d_out;
    logic [toce_pkg::XLEN-1:0]     d_val;
    logic                          d_wr;
    logic                          d_reg_we;
    logic [toce_pkg::PC_W-1:0]     d_npc;
    logic                          d_to_l;
    logic                          d_dm_re;
    logic                          d_dm_we;
    logic                          d_io_we;
    logic                          d_halt_set;

    toce_pkg::t_out                l_out;
    logic [toce_pkg::XLEN-1:0]     l_val;
    logic                          l_reg_we;

    function automatic logic [toce_pkg::XLEN-1:0] pick(
        input logic [toce_pkg::REG_AW-1:0] idx,
        input logic [toce_pkg::XLEN-1:0]   raw,
        input logic [toce_pkg::XLEN-1:0]   i1,
        input logic [toce_pkg::XLEN-1:0]   i2
    );
        logic [toce_pkg::XLEN-1:0] v;
        priority if (idx == toce_pkg::REG_ZERO) begin
            v = '0;
        end else if (idx == toce_pkg::REG_IMM_FIRST) begin
            v = i1;
        end else if (idx == toce_pkg::REG_IMM_SECOND) begin
            v = i2;
        end else begin
            v = raw;
        end
        return v;
    endfunction

    toce_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rf_rd),
        .i_wr    (rf_wr),
        .o_q     (rf_q)
    );

    toce_dmem u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dm_req),
        .o_rdata (dm_rdata),
        .o_busy  (dm_busy)
    );

    assign out_free = !r_o_vld || !i_out_stall;
    assign l_go     = r_l_vld && out_free;
    assign d_go     = r_d_vld && (d_to_l || out_free);
    assign in_ready = !dm_busy && (!r_d_vld || (d_go && !d_to_l)) && (!r_l_vld || l_go);
    assign accept   = i_in_valid && in_ready;
    assign o_in_stall = !in_ready;

    always_comb begin
        rf_rd.re     = accept;
        rf_rd.addr_a = i_in_item.src_a_reg;
        rf_rd.addr_b = i_in_item.src_b_reg;
        rf_rd.addr_c = i_in_item.src_c_reg;
        rf_rd.addr_d = i_in_item.dest_reg;
    end

    assign imm1 = {{(toce_pkg::XLEN-12){r_d.imm_first[11]}}, r_d.imm_first};
    assign imm2 = {{(toce_pkg::XLEN-12){r_d.imm_second[11]}}, r_d.imm_second};
    assign op_a = pick(r_d.src_a_reg, rf_q.a, imm1, imm2);
    assign op_b = pick(r_d.src_b_reg, rf_q.b, imm1, imm2);
    assign op_c = pick(r_d.src_c_reg, rf_q.c, imm1, imm2);
    assign op_d = pick(r_d.dest_reg, rf_q.d, imm1, imm2);

    assign sum_ab   = op_a + op_b;
    assign mem_full = sum_ab % toce_pkg::MEM_DEPTH;
    assign sh       = op_b[4:0];
    assign io_idx   = sum_ab[toce_pkg::IO_AW-1:0];
    assign io_ok    = ({1'b0, io_idx} < IoLimit);
    assign io_rd    = (io_ok && (io_idx != toce_pkg::IO_MONCMD_INDEX)) ? r_io[io_idx] : '0;
    assign sw_data  = op_c + op_d;
    assign pc_inc   = r_pc + 1'b1;
    assign target   = op_c[toce_pkg::PC_W-1:0];
    assign lt_ab    = $signed(op_a) < $signed(op_b);
    assign lt_ba    = $signed(op_b) < $signed(op_a);

    always_comb begin
        d_out      = '0;
        d_val      = '0;
        d_wr       = 1'b0;
        d_npc      = pc_inc;
        d_to_l     = 1'b0;
        d_dm_re    = 1'b0;
        d_dm_we    = 1'b0;
        d_io_we    = 1'b0;
        d_halt_set = 1'b0;
        if (r_halt) begin
            d_npc         = r_pc;
            d_out.halted  = 1'b1;
        end else begin
            unique case (r_d.op)
                toce_pkg::OP_ADD: begin
                    d_val = op_a + op_b + op_c;
                    d_wr  = 1'b1;
                end
                toce_pkg::OP_SUB: begin
                    d_val = op_a - op_b - op_c;
                    d_wr  = 1'b1;
                end
                toce_pkg::OP_MAC: begin
                    d_to_l = 1'b1;
                end
                toce_pkg::OP_AND: begin
                    d_val = op_a & op_b & op_c;
                    d_wr  = 1'b1;
                end
                toce_pkg::OP_OR: begin
                    d_val = op_a | op_b | op_c;
                    d_wr  = 1'b1;
                end
                toce_pkg::OP_XOR: begin
                    d_val = op_a ^ op_b ^ op_c;
                    d_wr  = 1'b1;
                end
                toce_pkg::OP_SLL: begin
                    d_val = op_a << sh;
                    d_wr  = 1'b1;
                end
                toce_pkg::OP_SRA: begin
                    d_val = $unsigned($signed(op_a) >>> sh);
                    d_wr  = 1'b1;
                end
                toce_pkg::OP_SRL: begin
                    d_val = op_a >> sh;
                    d_wr  = 1'b1;
                end
                toce_pkg::OP_BEQ: begin
                    if (op_a == op_b) begin
                        d_npc = target;
                    end
                end
                toce_pkg::OP_BNE: begin
                    if (op_a != op_b) begin
                        d_npc = target;
                    end
                end
                toce_pkg::OP_BLT: begin
                    if (lt_ab) begin
                        d_npc = target;
                    end
                end
                toce_pkg::OP_BGT: begin
                    if (lt_ba) begin
                        d_npc = target;
                    end
                end
                toce_pkg::OP_BLE: begin
                    if (!lt_ba) begin
                        d_npc = target;
                    end
                end
                toce_pkg::OP_BGE: begin
                    if (!lt_ab) begin
                        d_npc = target;
                    end
                end
                toce_pkg::OP_JAL: begin
                    d_val = {{(toce_pkg::XLEN-toce_pkg::PC_W){1'b0}}, pc_inc};
                    d_wr  = 1'b1;
                    d_npc = target;
                end
                toce_pkg::OP_LW: begin
                    d_to_l            = 1'b1;
                    d_dm_re           = 1'b1;
                    d_out.mem_address = mem_full[toce_pkg::PC_W-1:0];
                end
                toce_pkg::OP_SW: begin
                    d_dm_we           = 1'b1;
                    d_out.mem_written = 1'b1;
                    d_out.mem_address = mem_full[toce_pkg::PC_W-1:0];
                    d_out.mem_data    = sw_data;
                end
                toce_pkg::OP_RETI: begin
                    d_npc = r_io[toce_pkg::IO_RET_INDEX][toce_pkg::PC_W-1:0];
                    d_out.interrupt_returned = 1'b1;
                end
                toce_pkg::OP_IN: begin
                    d_out.io_access = toce_pkg::IO_READ;
                    d_out.io_index  = io_idx;
                    d_out.io_data   = io_rd;
                    d_val           = io_rd;
                    d_wr            = 1'b1;
                end
                toce_pkg::OP_OUT: begin
                    d_out.io_access = toce_pkg::IO_WRITE;
                    d_out.io_index  = io_idx;
                    d_out.io_data   = op_c;
                    d_io_we         = io_ok;
                end
                toce_pkg::OP_HALT: begin
                    d_halt_set   = 1'b1;
                    d_out.halted = 1'b1;
                end
                default: begin
                end
            endcase
        end
        d_reg_we = d_wr && (r_d.dest_reg >= toce_pkg::FIRST_WRITABLE);
        if (d_reg_we) begin
            d_out.reg_written = 1'b1;
            d_out.write_value = d_val;
        end
        d_out.next_pc = d_npc;
    end

    always_comb begin
        l_out    = r_l_out;
        l_val    = (r_l_lw ? dm_rdata : r_l_prod) + r_l_c;
        l_reg_we = (r_l_rd >= toce_pkg::FIRST_WRITABLE);
        if (r_l_lw) begin
            l_out.mem_data = dm_rdata;
        end
        if (l_reg_we) begin
            l_out.reg_written = 1'b1;
            l_out.write_value = l_val;
        end
    end

    always_comb begin
        rf_wr = '0;
        if (l_go && l_reg_we) begin
            rf_wr.we   = 1'b1;
            rf_wr.addr = r_l_rd;
            rf_wr.data = l_val;
        end else if (d_go && !d_to_l && d_reg_we) begin
            rf_wr.we   = 1'b1;
            rf_wr.addr = r_d.dest_reg;
            rf_wr.data = d_val;
        end
    end

    always_comb begin
        dm_req.re    = d_go && d_dm_re;
        dm_req.we    = d_go && d_dm_we;
        dm_req.addr  = mem_full[toce_pkg::MEM_AW-1:0];
        dm_req.wdata = sw_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
            r_l_vld <= 1'b0;
            r_o_vld <= 1'b0;
            r_pc    <= '0;
            r_halt  <= 1'b0;
        end else begin
            if (accept) begin
                r_d_vld <= 1'b1;
            end else if (d_go) begin
                r_d_vld <= 1'b0;
            end
            if (d_go && d_to_l) begin
                r_l_vld <= 1'b1;
            end else if (l_go) begin
                r_l_vld <= 1'b0;
            end
            if ((d_go && !d_to_l) || l_go) begin
                r_o_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_vld <= 1'b0;
            end
            if (d_go) begin
                r_pc   <= d_npc;
                r_halt <= r_halt | d_halt_set;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_d <= i_in_item;
        end
        if (d_go && d_to_l) begin
            r_l_lw   <= d_dm_re;
            r_l_rd   <= r_d.dest_reg;
            r_l_c    <= op_c;
            r_l_prod <= op_a * op_b;
            r_l_out  <= d_out;
        end
        if (d_go && !d_to_l) begin
            r_o <= d_out;
        end else if (l_go) begin
            r_o <= l_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < IoDepth; k++) begin
                r_io[k] <= '0;
            end
        end else if (d_go && d_io_we) begin
            r_io[io_idx] <= op_c;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_out_item  = r_o;

    `TOCE_ASSERT_SAME(a_single_stage_busy, r_d_vld, !r_l_vld, "operand and load stages both hold items")
    `TOCE_ASSERT_SAME(a_halt_no_write, r_halt, !rf_wr.we, "register write after halt")
    `TOCE_ASSERT_NEXT(a_halt_result, d_go && !d_to_l && r_halt, o_out_valid && o_out_item.halted, "halted result not flagged")

endmodule

`default_nettype wire
